[rtl/pga_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pga_pkg
// Shared constants for the per-pool page allocator: field widths, defaults
// and result status codes.
// ----------------------------------------------------------------------------
package pga_pkg;

    localparam int NUM_POOLS_DEF  = 8;
    localparam int POOL_DEPTH_DEF = 1024;

    localparam int FRAME_W   = 40;
    localparam int POOL_ID_W = 3;
    localparam int CNT_W     = 11;
    localparam int STATUS_W  = 3;

    localparam int BATCH_CAP = 1024;
    localparam logic [CNT_W-1:0] STEAL_BATCH_RESET = 11'd100;

    localparam logic [STATUS_W-1:0] STAT_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL_STEAL  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_SHORT_STEAL = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NONE        = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_DROPPED     = 3'd4;

endpackage
`default_nettype wire

[rtl/pga_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pga_ram
// Generic simple dual-port RAM, one write port, one read port with
// registered read data held between reads.
// ----------------------------------------------------------------------------
module pga_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[rtl/pga_fill.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pga_fill
// Per-pool fill counts: a small RAM plus one valid bit per pool so that
// every pool reads as empty after reset.
// ----------------------------------------------------------------------------
module pga_fill #(
    parameter int NUM_POOLS = pga_pkg::NUM_POOLS_DEF,
    parameter int FW        = 11,
    localparam int PW       = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          we,
    input  wire logic [PW-1:0] waddr,
    input  wire logic [FW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [PW-1:0] raddr,
    output logic      [FW-1:0] rdata
);

    logic [NUM_POOLS-1:0] valid_reg;
    logic [NUM_POOLS-1:0] valid_next;
    logic                 rd_valid_reg;
    logic [FW-1:0]        ram_q;

    pga_ram #(
        .WIDTH (FW),
        .DEPTH (NUM_POOLS)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (ram_q)
    );

    always_comb begin
        valid_next = valid_reg;
        if (we) begin
            valid_next[waddr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (re) begin
                rd_valid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rd_valid_reg ? ram_q : '0;

endmodule
`default_nettype wire

[rtl/pga_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pga_ctrl
// Sequencer for puts, gets and the steal walk over the other pools. Drives
// the frame memory and the fill-count store and holds the output word.
// ----------------------------------------------------------------------------
module pga_ctrl #(
    parameter int NUM_POOLS  = pga_pkg::NUM_POOLS_DEF,
    parameter int POOL_DEPTH = pga_pkg::POOL_DEPTH_DEF,
    localparam int PW        = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1,
    localparam int IDXW      = $clog2(POOL_DEPTH),
    localparam int FW        = $clog2(POOL_DEPTH + 1),
    localparam int MAW       = PW + IDXW
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [pga_pkg::CNT_W-1:0]      steal_batch,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           in_func,
    input  wire logic [pga_pkg::POOL_ID_W-1:0]  in_pool_id,
    input  wire logic [pga_pkg::FRAME_W-1:0]    in_page_frame,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [pga_pkg::FRAME_W-1:0]    out_frame,
    output logic      [pga_pkg::STATUS_W-1:0]   out_status,
    output logic      [pga_pkg::CNT_W-1:0]      out_stolen,
    output logic                                fm_we,
    output logic      [MAW-1:0]                 fm_waddr,
    output logic      [pga_pkg::FRAME_W-1:0]    fm_wdata,
    output logic                                fm_re,
    output logic      [MAW-1:0]                 fm_raddr,
    input  wire logic [pga_pkg::FRAME_W-1:0]    fm_rdata,
    output logic                                fc_we,
    output logic      [PW-1:0]                  fc_waddr,
    output logic      [FW-1:0]                  fc_wdata,
    output logic                                fc_re,
    output logic      [PW-1:0]                  fc_raddr,
    input  wire logic [FW-1:0]                  fc_rdata
);

    localparam int CW = pga_pkg::CNT_W;
    localparam int FRW = pga_pkg::FRAME_W;
    localparam int SW = pga_pkg::STATUS_W;
    localparam int CAP_I = (pga_pkg::BATCH_CAP < POOL_DEPTH) ? pga_pkg::BATCH_CAP : POOL_DEPTH;
    localparam logic [CW-1:0] CAP = CW'(CAP_I);
    localparam logic [6:0] NPOOLS7 = 7'(NUM_POOLS);
    localparam logic [PW-1:0] LAST_POOL = PW'(NUM_POOLS - 1);
    localparam logic [FW-1:0] DEPTH_F = FW'(POOL_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_POP,
        S_SCAN,
        S_MOVE,
        S_FIN,
        S_OUT
    } state_t;

    state_t          state_reg, state_next;
    logic            func_reg, func_next;
    logic [PW-1:0]   pid_reg, pid_next;
    logic [FRW-1:0]  frame_reg, frame_next;
    logic [PW-1:0]   tgt_reg, tgt_next;
    logic [FW-1:0]   tfill_reg, tfill_next;
    logic [CW-1:0]   want_reg, want_next;
    logic [CW-1:0]   icnt_reg, icnt_next;
    logic [CW-1:0]   wcnt_reg, wcnt_next;
    logic            pend_reg, pend_next;
    logic [FRW-1:0]  last_reg, last_next;
    logic [FRW-1:0]  res_frame_reg, res_frame_next;
    logic [SW-1:0]   res_status_reg, res_status_next;
    logic [CW-1:0]   res_stolen_reg, res_stolen_next;
    logic            m_valid_reg, m_valid_next;
    logic [FRW-1:0]  m_frame_reg, m_frame_next;
    logic [SW-1:0]   m_status_reg, m_status_next;
    logic [CW-1:0]   m_stolen_reg, m_stolen_next;

    logic            pid_ok;
    logic [CW-1:0]   batch;
    logic [PW-1:0]   pid_after;
    logic [PW-1:0]   tgt_after;
    logic            can_issue;

    function automatic logic [PW-1:0] next_pool(input logic [PW-1:0] p);
        next_pool = (p == LAST_POOL) ? '0 : p + PW'(1);
    endfunction

    always_comb begin
        pid_ok    = ({4'b0, in_pool_id} < NPOOLS7);
        batch     = (steal_batch == '0) ? CW'(1) : steal_batch;
        if (batch > CAP) begin
            batch = CAP;
        end
        pid_after = next_pool(pid_reg);
        tgt_after = next_pool(tgt_reg);
        can_issue = (icnt_reg < want_reg) && (tfill_reg != '0);
    end

    always_comb begin
        state_next      = state_reg;
        func_next       = func_reg;
        pid_next        = pid_reg;
        frame_next      = frame_reg;
        tgt_next        = tgt_reg;
        tfill_next      = tfill_reg;
        want_next       = want_reg;
        icnt_next       = icnt_reg;
        wcnt_next       = wcnt_reg;
        pend_next       = pend_reg;
        last_next       = last_reg;
        res_frame_next  = res_frame_reg;
        res_status_next = res_status_reg;
        res_stolen_next = res_stolen_reg;
        m_valid_next    = m_valid_reg;
        m_frame_next    = m_frame_reg;
        m_status_next   = m_status_reg;
        m_stolen_next   = m_stolen_reg;

        in_ready = (state_reg == S_IDLE);
        fm_we    = 1'b0;
        fm_waddr = '0;
        fm_wdata = '0;
        fm_re    = 1'b0;
        fm_raddr = '0;
        fc_we    = 1'b0;
        fc_waddr = '0;
        fc_wdata = '0;
        fc_re    = 1'b0;
        fc_raddr = '0;

        if (m_valid_reg && out_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    func_next       = in_func;
                    pid_next        = PW'(in_pool_id);
                    frame_next      = in_page_frame;
                    res_frame_next  = '0;
                    res_stolen_next = '0;
                    if (!pid_ok) begin
                        res_status_next = in_func ? pga_pkg::STAT_DROPPED
                                                  : pga_pkg::STAT_NONE;
                        state_next      = S_OUT;
                    end else begin
                        fc_re      = 1'b1;
                        fc_raddr   = PW'(in_pool_id);
                        state_next = S_FILL;
                    end
                end
            end
            S_FILL: begin
                if (func_reg) begin
                    if (fc_rdata >= DEPTH_F) begin
                        res_status_next = pga_pkg::STAT_DROPPED;
                    end else begin
                        fm_we           = 1'b1;
                        fm_waddr        = {pid_reg, IDXW'(fc_rdata)};
                        fm_wdata        = frame_reg;
                        fc_we           = 1'b1;
                        fc_waddr        = pid_reg;
                        fc_wdata        = fc_rdata + FW'(1);
                        res_status_next = pga_pkg::STAT_OK;
                    end
                    state_next = S_OUT;
                end else if (fc_rdata != '0) begin
                    fm_re      = 1'b1;
                    fm_raddr   = {pid_reg, IDXW'(fc_rdata - FW'(1))};
                    fc_we      = 1'b1;
                    fc_waddr   = pid_reg;
                    fc_wdata   = fc_rdata - FW'(1);
                    state_next = S_POP;
                end else begin
                    want_next  = batch;
                    icnt_next  = '0;
                    wcnt_next  = '0;
                    pend_next  = 1'b0;
                    tgt_next   = pid_after;
                    fc_re      = 1'b1;
                    fc_raddr   = pid_after;
                    state_next = S_SCAN;
                end
            end
            S_POP: begin
                res_frame_next  = fm_rdata;
                res_status_next = pga_pkg::STAT_OK;
                state_next      = S_OUT;
            end
            S_SCAN: begin
                if (fc_rdata != '0) begin
                    tfill_next = fc_rdata;
                    state_next = S_MOVE;
                end else if (tgt_after == pid_reg) begin
                    state_next = S_FIN;
                end else begin
                    tgt_next = tgt_after;
                    fc_re    = 1'b1;
                    fc_raddr = tgt_after;
                end
            end
            S_MOVE: begin
                // read of the next victim frame overlaps the write of the last one
                if (pend_reg) begin
                    fm_we     = 1'b1;
                    fm_waddr  = {pid_reg, IDXW'(wcnt_reg)};
                    fm_wdata  = fm_rdata;
                    last_next = fm_rdata;
                    wcnt_next = wcnt_reg + CW'(1);
                end
                if (can_issue) begin
                    fm_re      = 1'b1;
                    fm_raddr   = {tgt_reg, IDXW'(tfill_reg - FW'(1))};
                    tfill_next = tfill_reg - FW'(1);
                    icnt_next  = icnt_reg + CW'(1);
                    pend_next  = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        fc_we    = 1'b1;
                        fc_waddr = tgt_reg;
                        fc_wdata = tfill_reg;
                        if ((icnt_reg == want_reg) || (tgt_after == pid_reg)) begin
                            state_next = S_FIN;
                        end else begin
                            tgt_next   = tgt_after;
                            fc_re      = 1'b1;
                            fc_raddr   = tgt_after;
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_FIN: begin
                if (icnt_reg == '0) begin
                    res_status_next = pga_pkg::STAT_NONE;
                end else begin
                    fc_we           = 1'b1;
                    fc_waddr        = pid_reg;
                    fc_wdata        = FW'(icnt_reg) - FW'(1);
                    res_frame_next  = last_reg;
                    res_stolen_next = icnt_reg;
                    res_status_next = (icnt_reg == want_reg) ? pga_pkg::STAT_FULL_STEAL
                                                             : pga_pkg::STAT_SHORT_STEAL;
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || out_ready) begin
                    m_valid_next  = 1'b1;
                    m_frame_next  = res_frame_reg;
                    m_status_next = res_status_reg;
                    m_stolen_next = res_stolen_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
        end
        func_reg       <= func_next;
        pid_reg        <= pid_next;
        frame_reg      <= frame_next;
        tgt_reg        <= tgt_next;
        tfill_reg      <= tfill_next;
        want_reg       <= want_next;
        icnt_reg       <= icnt_next;
        wcnt_reg       <= wcnt_next;
        last_reg       <= last_next;
        res_frame_reg  <= res_frame_next;
        res_status_reg <= res_status_next;
        res_stolen_reg <= res_stolen_next;
        m_frame_reg    <= m_frame_next;
        m_status_reg   <= m_status_next;
        m_stolen_reg   <= m_stolen_next;
    end

    assign out_valid  = m_valid_reg;
    assign out_frame  = m_frame_reg;
    assign out_status = m_status_reg;
    assign out_stolen = m_stolen_reg;

endmodule
`default_nettype wire

[rtl/per_pool_page_allocator_with_stealing.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// per_pool_page_allocator_with_stealing
// LIFO pools of free page frames in one frame memory; an empty-pool get
// steals a batch from the other pools in round-robin order.
// ----------------------------------------------------------------------------
// Words are handled one at a time. A put reads the fill count, writes the
// frame memory and loads the output word. A get from a non-empty pool adds
// a memory read before the output load. A request to an unknown pool goes
// straight to the output load. A get from an empty pool walks the other
// pools, checking each fill count and moving frames from each non-empty
// pool until the batch is met or all are checked. The frame memory's single
// read port sets the pace of the move. The output word is registered, so a
// new word is accepted while a result still waits on m_tready. Fill counts
// start at zero through per-pool valid bits; no clearing pass after reset.
// ----------------------------------------------------------------------------
module per_pool_page_allocator_with_stealing #(
    parameter int NUM_POOLS  = pga_pkg::NUM_POOLS_DEF,
    parameter int POOL_DEPTH = pga_pkg::POOL_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [10:0] cfg_wr_data,   // steal_batch
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,       // pool_id[2:0], page_frame[42:3], zero pad
    input  wire logic [0:0]  s_tuser,       // func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [55:0] m_tdata        // frame_out[39:0], status[42:40],
                                            // stolen_count[53:43], zero pad
);

    localparam int PW   = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
    localparam int IDXW = $clog2(POOL_DEPTH);
    localparam int FW   = $clog2(POOL_DEPTH + 1);
    localparam int MAW  = PW + IDXW;
    localparam int FRW  = pga_pkg::FRAME_W;

    logic [pga_pkg::CNT_W-1:0]    steal_batch_reg;
    logic [FRW-1:0]               out_frame;
    logic [pga_pkg::STATUS_W-1:0] out_status;
    logic [pga_pkg::CNT_W-1:0]    out_stolen;

    logic           fm_we, fm_re;
    logic [MAW-1:0] fm_waddr, fm_raddr;
    logic [FRW-1:0] fm_wdata, fm_rdata;
    logic           fc_we, fc_re;
    logic [PW-1:0]  fc_waddr, fc_raddr;
    logic [FW-1:0]  fc_wdata, fc_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steal_batch_reg <= pga_pkg::STEAL_BATCH_RESET;
        end else if (cfg_wr_en) begin
            steal_batch_reg <= cfg_wr_data;
        end
    end

    pga_ctrl #(
        .NUM_POOLS  (NUM_POOLS),
        .POOL_DEPTH (POOL_DEPTH)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .steal_batch   (steal_batch_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_func       (s_tuser[0]),
        .in_pool_id    (s_tdata[2:0]),
        .in_page_frame (s_tdata[42:3]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_frame     (out_frame),
        .out_status    (out_status),
        .out_stolen    (out_stolen),
        .fm_we         (fm_we),
        .fm_waddr      (fm_waddr),
        .fm_wdata      (fm_wdata),
        .fm_re         (fm_re),
        .fm_raddr      (fm_raddr),
        .fm_rdata      (fm_rdata),
        .fc_we         (fc_we),
        .fc_waddr      (fc_waddr),
        .fc_wdata      (fc_wdata),
        .fc_re         (fc_re),
        .fc_raddr      (fc_raddr),
        .fc_rdata      (fc_rdata)
    );

    pga_ram #(
        .WIDTH (FRW),
        .DEPTH (NUM_POOLS * (1 << IDXW))
    ) u_frame_store (
        .aclk  (aclk),
        .we    (fm_we),
        .waddr (fm_waddr),
        .wdata (fm_wdata),
        .re    (fm_re),
        .raddr (fm_raddr),
        .rdata (fm_rdata)
    );

    pga_fill #(
        .NUM_POOLS (NUM_POOLS),
        .FW        (FW)
    ) u_pool_fill (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (fc_we),
        .waddr   (fc_waddr),
        .wdata   (fc_wdata),
        .re      (fc_re),
        .raddr   (fc_raddr),
        .rdata   (fc_rdata)
    );

    assign m_tdata = {2'b00, out_stolen, out_status, out_frame};

endmodule
`default_nettype wire

[test/tb_per_pool_page_allocator_with_stealing.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_per_pool_page_allocator_with_stealing
// Self-checking bench for the page allocator. Requests go in on the s_ stream
// and replies come back on the m_ stream. A shadow copy of every pool predicts
// each reply, including round-robin steals and full-pool drops. The steal
// batch register is rewritten between phases. Both sides idle at random, and
// in one phase the reply side holds off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_per_pool_page_allocator_with_stealing;

    localparam int POOL_COUNT = pga_pkg::NUM_POOLS_DEF;
    localparam int POOL_DEPTH = pga_pkg::POOL_DEPTH_DEF;
    localparam int STALL_LIMIT = 8000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic [pga_pkg::FRAME_W-1:0]  frame;
        logic [pga_pkg::STATUS_W-1:0] status;
        logic [pga_pkg::CNT_W-1:0]    stolen;
    } alloc_reply_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [10:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;       // pool_id[2:0], page_frame[42:3], zero pad
    logic [0:0]  s_tuser;       // func
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;       // frame_out[39:0], status[42:40], stolen_count[53:43], pad

    logic [pga_pkg::FRAME_W-1:0] shadow_frames [POOL_COUNT][POOL_DEPTH];
    int unsigned                 shadow_fill [POOL_COUNT];
    logic [pga_pkg::CNT_W-1:0]   shadow_batch;

    alloc_reply_t owed_replies [$];
    int error_count = 0;
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int hold_off_left = 0;

    per_pool_page_allocator_with_stealing u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic alloc_reply_t predict_reply(input logic is_put, input logic [2:0] pool,
                                                   input logic [pga_pkg::FRAME_W-1:0] frame);
        alloc_reply_t r;
        int unsigned  want;
        int unsigned  got;
        int unsigned  victim;
        int unsigned  p;
        r = '0;
        r.status = pga_pkg::STAT_OK;
        got = 0;
        p = pool;
        if (is_put == OP_PUT) begin
            if (p >= POOL_COUNT || shadow_fill[p] >= POOL_DEPTH) begin
                r.status = pga_pkg::STAT_DROPPED;
            end else begin
                shadow_frames[p][shadow_fill[p]] = frame;
                shadow_fill[p]++;
            end
        end else if (p >= POOL_COUNT) begin
            r.status = pga_pkg::STAT_NONE;
        end else begin
            if (shadow_fill[p] == 0) begin
                want = shadow_batch;
                if (want == 0) want = 1;
                if (want > pga_pkg::BATCH_CAP) want = pga_pkg::BATCH_CAP;
                if (want > POOL_DEPTH) want = POOL_DEPTH;
                victim = (p + 1) % POOL_COUNT;
                while (got < want && victim != p) begin
                    while (got < want && shadow_fill[victim] > 0) begin
                        shadow_fill[victim]--;
                        shadow_frames[p][shadow_fill[p]] = shadow_frames[victim][shadow_fill[victim]];
                        shadow_fill[p]++;
                        got++;
                    end
                    victim = (victim + 1) % POOL_COUNT;
                end
                if (got == 0) r.status = pga_pkg::STAT_NONE;
                else if (got == want) r.status = pga_pkg::STAT_FULL_STEAL;
                else r.status = pga_pkg::STAT_SHORT_STEAL;
            end
            if (shadow_fill[p] > 0) begin
                shadow_fill[p]--;
                r.frame = shadow_frames[p][shadow_fill[p]];
            end
        end
        r.stolen = got[pga_pkg::CNT_W-1:0];
        return r;
    endfunction

    function automatic logic [pga_pkg::FRAME_W-1:0] random_frame();
        int unsigned pick;
        pick = $urandom_range(15);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return {8'($urandom_range(255)), 32'($urandom())};
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (error_count <= 100)
            $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic send_word(input logic is_put, input logic [2:0] pool,
                             input logic [pga_pkg::FRAME_W-1:0] frame);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = is_put;
        s_tdata  = {5'b0, frame, pool};
        do @(posedge aclk); while (!s_tready);
        owed_replies.insert(owed_replies.size(), predict_reply(is_put, pool, frame));
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (owed_replies.size() != 0) @(posedge aclk);
    endtask

    task automatic write_batch(input logic [pga_pkg::CNT_W-1:0] value);
        wait_drained();
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        shadow_batch = value;
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        sender_idle_pct   = sender_pct;
        receiver_idle_pct = receiver_pct;
    endtask

    task automatic run_random_block(input int count, input int get_pct);
        repeat (count) begin
            if ($urandom_range(99) < get_pct)
                send_word(OP_GET, 3'($urandom_range(7)), random_frame());
            else
                send_word(OP_PUT, 3'($urandom_range(7)), random_frame());
        end
    endtask

    // empty system, frame zero, LIFO order, short and full steals, batch of zero
    task automatic test_directed();
        send_word(OP_GET, 3'd3, 40'hFF_FFFF_FFFF);
        send_word(OP_PUT, 3'd2, '0);
        send_word(OP_GET, 3'd2, '0);
        send_word(OP_GET, 3'd2, '0);
        send_word(OP_PUT, 3'd5, 40'hFF_FFFF_FFFF);
        send_word(OP_PUT, 3'd5, 40'h55_5555_5555);
        send_word(OP_PUT, 3'd5, 40'hAA_AAAA_AAAA);
        send_word(OP_GET, 3'd5, '0);
        send_word(OP_PUT, 3'd6, 40'd1);
        send_word(OP_PUT, 3'd0, 40'd2);
        send_word(OP_PUT, 3'd7, 40'd3);
        send_word(OP_GET, 3'd4, '0);
        write_batch(11'd0);
        send_word(OP_GET, 3'd1, '0);
        write_batch(11'd1);
        send_word(OP_GET, 3'd2, '0);
        send_word(OP_GET, 3'd4, '0);
        send_word(OP_GET, 3'd4, '0);
    endtask

    // steal a maximal batch into an empty pool, then overflow it
    task automatic test_pool_capacity();
        int target;
        int donor;
        target = 0;
        for (int p = POOL_COUNT - 1; p >= 0; p--)
            if (shadow_fill[p] == 0) target = p;
        repeat (POOL_DEPTH + 6) begin
            donor = $urandom_range(POOL_COUNT - 2);
            if (donor >= target) donor++;
            send_word(OP_PUT, 3'(donor), random_frame());
        end
        write_batch(11'd2047);
        send_word(OP_GET, 3'(target), random_frame());
        send_word(OP_PUT, 3'(target), random_frame());
        send_word(OP_PUT, 3'(target), random_frame());
        send_word(OP_PUT, 3'(target), random_frame());
        send_word(OP_GET, 3'(target), random_frame());
        send_word(OP_GET, 3'(target), random_frame());
    endtask

    task automatic test_random_traffic(input logic [pga_pkg::CNT_W-1:0] batch_a,
                                       input logic [pga_pkg::CNT_W-1:0] batch_b,
                                       input logic [pga_pkg::CNT_W-1:0] batch_c);
        write_batch(batch_a);
        run_random_block(70, 45);
        write_batch(batch_b);
        run_random_block(70, 55);
        write_batch(batch_c);
        run_random_block(70, 65);
    endtask

    // reply side blocked while requests keep coming
    task automatic test_backpressure();
        wait_drained();
        @(posedge aclk);
        hold_off_left = HOLD_OFF_CYCLES;
        run_random_block(40, 50);
        wait_drained();
    endtask

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_left > 0) begin
                m_tready = 1'b0;
                hold_off_left--;
            end else begin
                m_tready = ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        alloc_reply_t want;
        alloc_reply_t got;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready) begin
            got.frame  = m_tdata[39:0];
            got.status = m_tdata[42:40];
            got.stolen = m_tdata[53:43];
            if (owed_replies.size() == 0) begin
                report_mismatch("unexpected word", 64'(got), 64'd0);
            end else begin
                want = owed_replies.pop_front();
                if (got.frame !== want.frame)
                    report_mismatch("frame_out", 64'(got.frame), 64'(want.frame));
                if (got.status !== want.status)
                    report_mismatch("status", 64'(got.status), 64'(want.status));
                if (got.stolen !== want.stolen)
                    report_mismatch("stolen_count", 64'(got.stolen), 64'(want.stolen));
            end
        end
    end

    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("tb_per_pool_page_allocator_with_stealing: done, errors");
        $finish;
    end

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        shadow_batch = pga_pkg::STEAL_BATCH_RESET;
        for (int p = 0; p < POOL_COUNT; p++) shadow_fill[p] = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        set_idling(35, 65);
        test_directed();
        test_pool_capacity();
        test_random_traffic(11'd1, 11'd12, 11'd0);
        set_idling(65, 35);
        test_random_traffic(11'd2047, 11'd1023, 11'($urandom_range(2, 64)));
        set_idling(0, 0);
        test_backpressure();
        test_random_traffic(11'd1024, 11'd100, 11'($urandom_range(1, 2047)));

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (owed_replies.size() != 0)
            report_mismatch("missing words", 64'(owed_replies.size()), 64'd0);
        if (error_count == 0)
            $display("tb_per_pool_page_allocator_with_stealing: done, clean");
        else
            $display("tb_per_pool_page_allocator_with_stealing: done, errors");
        $finish;
    end

endmodule
